// ===== hw/rtl/three_rotor_reflector_cipher_core_defines.svh =====
// Assertion macros for the three-rotor reflector cipher core.
// Taken in by the files that carry concurrent assertions; no other dependencies.
`ifndef THREE_ROTOR_REFLECTOR_CIPHER_CORE_DEFINES_SVH
`define THREE_ROTOR_REFLECTOR_CIPHER_CORE_DEFINES_SVH

// Condition must hold at every edge out of reset.
`define TRRC_ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TRRC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/trrc_pkg.sv =====
// Shared types, wiring tables and mod-26 helpers for the rotor cipher core.
// No dependencies; used by trrc_cipher_path and the top level.
package trrc_pkg;

    localparam int NLET = 26;

    localparam logic [7:0] CHAR_A = 8'h41;
    localparam logic [7:0] CHAR_Z = 8'h5A;

    typedef logic [4:0] letter_t;
    typedef logic [5:0] phase_t;
    typedef logic [NLET-1:0][4:0] wire_t;

    typedef struct packed {
        letter_t fast;
        letter_t mid;
        letter_t slow;
    } rotor_pos_t;

    typedef enum logic [2:0] {
        REG_FAST_START  = 3'd0,
        REG_MID_START   = 3'd1,
        REG_SLOW_START  = 3'd2,
        REG_MID_PERIOD  = 3'd3,
        REG_SLOW_PERIOD = 3'd4
    } cfg_reg_t;

    localparam letter_t RESET_FAST_START  = 5'd20;
    localparam letter_t RESET_MID_START   = 5'd10;
    localparam letter_t RESET_SLOW_START  = 5'd19;
    localparam phase_t  RESET_MID_PERIOD  = 6'd4;
    localparam phase_t  RESET_SLOW_PERIOD = 6'd11;
    localparam letter_t HALF_TURN         = 5'd13;

    localparam logic [8*NLET-1:0] WIRE_FAST_STR = "VFTYQMDRIOLGHUKZNABWXSJECP";
    localparam logic [8*NLET-1:0] WIRE_MID_STR  = "XGMPSALUFVKHJZTWRCINOBYDQE";
    localparam logic [8*NLET-1:0] WIRE_SLOW_STR = "UCLHXATGZRNFOJBIEVSYWPDMKQ";
    localparam logic [8*NLET-1:0] WIRE_REFL_STR = "GKWRVLSHAJUQPDNIMYFTOEBXZC";

    // (a - n) mod 26 for a, n below 26
    function automatic letter_t sub26(input letter_t a, input letter_t n);
        logic [5:0] d;
        d = {1'b0, a} + 6'(NLET) - {1'b0, n};
        return (d >= 6'(NLET)) ? 5'(d - 6'(NLET)) : 5'(d);
    endfunction

    // (a + n) mod 26 for a, n below 26
    function automatic letter_t add26(input letter_t a, input letter_t n);
        logic [5:0] s;
        s = {1'b0, a} + {1'b0, n};
        return (s >= 6'(NLET)) ? 5'(s - 6'(NLET)) : 5'(s);
    endfunction

    function automatic letter_t inc26(input letter_t a);
        return (a == 5'(NLET - 1)) ? 5'd0 : a + 5'd1;
    endfunction

    function automatic letter_t reduce26(input letter_t a);
        return (a >= 5'(NLET)) ? 5'(a - 5'(NLET)) : a;
    endfunction

    function automatic wire_t str_to_wire(input logic [8*NLET-1:0] s);
        wire_t w;
        for (int k = 0; k < NLET; k++) begin
            w[k] = 5'(s[8*(NLET-1-k) +: 8] - CHAR_A);
        end
        return w;
    endfunction

    function automatic wire_t invert_wire(input wire_t w);
        wire_t r;
        r = '0;
        for (int k = 0; k < NLET; k++) begin
            r[w[k]] = 5'(k);
        end
        return r;
    endfunction

    // Reflector: letter at table position p maps to the letter at p + 13.
    function automatic wire_t build_refl(input wire_t w);
        wire_t inv;
        wire_t r;
        inv = invert_wire(w);
        for (int k = 0; k < NLET; k++) begin
            r[k] = w[add26(inv[k], HALF_TURN)];
        end
        return r;
    endfunction

    localparam wire_t FWD_FAST = str_to_wire(WIRE_FAST_STR);
    localparam wire_t FWD_MID  = str_to_wire(WIRE_MID_STR);
    localparam wire_t FWD_SLOW = str_to_wire(WIRE_SLOW_STR);
    localparam wire_t INV_FAST = invert_wire(FWD_FAST);
    localparam wire_t INV_MID  = invert_wire(FWD_MID);
    localparam wire_t INV_SLOW = invert_wire(FWD_SLOW);
    localparam wire_t REFL     = build_refl(str_to_wire(WIRE_REFL_STR));

endpackage

// ===== hw/rtl/trrc_cipher_path.sv =====
// Single-pass letter path: three rotors forward, reflector, three rotors back.
// Depends on trrc_pkg for wiring tables and mod-26 helpers.
module trrc_cipher_path
    import trrc_pkg::*;
(
    input  logic [7:0]  char_in,
    input  logic        is_letter,
    input  rotor_pos_t  pos,
    output logic [7:0]  char_out
);

    letter_t l_in;
    letter_t f_fast;
    letter_t f_mid;
    letter_t f_slow;
    letter_t refl;
    letter_t b_slow;
    letter_t b_mid;
    letter_t b_fast;

    always_comb begin
        l_in   = 5'(char_in - CHAR_A);
        f_fast = FWD_FAST[sub26(l_in, pos.fast)];
        f_mid  = FWD_MID[sub26(f_fast, pos.mid)];
        f_slow = FWD_SLOW[sub26(f_mid, pos.slow)];
        refl   = REFL[f_slow];
        b_slow = add26(INV_SLOW[refl], pos.slow);
        b_mid  = add26(INV_MID[b_slow], pos.mid);
        b_fast = add26(INV_FAST[b_mid], pos.fast);
        // non-letters pass untouched
        char_out = is_letter ? (CHAR_A + {3'b000, b_fast}) : char_in;
    end

endmodule

// ===== hw/rtl/three_rotor_reflector_cipher_core.sv =====
// Three-rotor reflector cipher core: one byte in, one byte out per beat.
// Input register, then result register, between input accept and m_valid.
// One beat per cycle while m_ready keeps up; stepping and table path are combinational.
// Reset (aresetn low, synchronous): start positions 20/10/19, periods 4/11,
// rotors at their start positions, phases cleared, both stages empty.
// Depends on trrc_pkg, trrc_cipher_path and the defines header.
`include "three_rotor_reflector_cipher_core_defines.svh"

module three_rotor_reflector_cipher_core
    import trrc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [5:0]  cfg_wdata,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_char_in,
    input  logic        s_new_message,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_char_out
);

    // configuration
    letter_t fast_start_reg, mid_start_reg, slow_start_reg;
    phase_t  mid_period_reg, slow_period_reg;

    // rotor state
    rotor_pos_t pos_reg, pos_next;
    phase_t     mid_phase_reg, mid_phase_next;
    phase_t     slow_phase_reg, slow_phase_next;

    // input stage
    logic       s1_valid_reg, s1_valid_next;
    logic [7:0] s1_char_reg;
    logic       s1_letter_reg;
    rotor_pos_t s1_pos_reg;

    // result stage
    logic       m_valid_reg, m_valid_next;
    logic [7:0] m_char_reg;
    logic [7:0] path_char;

    logic       s2_open;
    logic       s1_advance;
    logic       in_accept;
    logic       in_letter;
    rotor_pos_t cur_pos;
    phase_t     cur_mid_phase, cur_slow_phase;
    phase_t     mid_tick, slow_tick;

    assign s2_open    = !m_valid_reg || m_ready;
    assign s1_advance = s1_valid_reg && s2_open;
    assign s_ready    = !s1_valid_reg || s2_open;
    assign in_accept  = s_valid && s_ready;
    assign in_letter  = s_char_in inside {[CHAR_A:CHAR_Z]};

    assign m_valid    = m_valid_reg;
    assign m_char_out = m_char_reg;

    always_comb begin
        // reload start positions ahead of this beat on a new message
        if (s_new_message) begin
            cur_pos.fast   = reduce26(fast_start_reg);
            cur_pos.mid    = reduce26(mid_start_reg);
            cur_pos.slow   = reduce26(slow_start_reg);
            cur_mid_phase  = '0;
            cur_slow_phase = '0;
        end else begin
            cur_pos        = pos_reg;
            cur_mid_phase  = mid_phase_reg;
            cur_slow_phase = slow_phase_reg;
        end

        mid_tick  = cur_mid_phase + 6'd1;
        slow_tick = cur_slow_phase + 6'd1;

        pos_next        = pos_reg;
        mid_phase_next  = mid_phase_reg;
        slow_phase_next = slow_phase_reg;

        if (in_accept) begin
            pos_next        = cur_pos;
            mid_phase_next  = cur_mid_phase;
            slow_phase_next = cur_slow_phase;
            if (in_letter) begin
                pos_next.fast = inc26(cur_pos.fast);
                if (mid_tick == mid_period_reg) begin
                    mid_phase_next = '0;
                    pos_next.mid   = inc26(cur_pos.mid);
                end else begin
                    mid_phase_next = mid_tick;
                end
                if (slow_tick == slow_period_reg) begin
                    slow_phase_next = '0;
                    pos_next.slow   = inc26(cur_pos.slow);
                end else begin
                    slow_phase_next = slow_tick;
                end
            end
        end

        if (in_accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_advance) begin
            s1_valid_next = 1'b0;
        end else begin
            s1_valid_next = s1_valid_reg;
        end

        m_valid_next = s2_open ? s1_valid_reg : m_valid_reg;
    end

    trrc_cipher_path u_path (
        .char_in   (s1_char_reg),
        .is_letter (s1_letter_reg),
        .pos       (s1_pos_reg),
        .char_out  (path_char)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fast_start_reg  <= RESET_FAST_START;
            mid_start_reg   <= RESET_MID_START;
            slow_start_reg  <= RESET_SLOW_START;
            mid_period_reg  <= RESET_MID_PERIOD;
            slow_period_reg <= RESET_SLOW_PERIOD;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                REG_FAST_START:  fast_start_reg  <= cfg_wdata[4:0];
                REG_MID_START:   mid_start_reg   <= cfg_wdata[4:0];
                REG_SLOW_START:  slow_start_reg  <= cfg_wdata[4:0];
                REG_MID_PERIOD:  mid_period_reg  <= cfg_wdata;
                REG_SLOW_PERIOD: slow_period_reg <= cfg_wdata;
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg.fast   <= RESET_FAST_START;
            pos_reg.mid    <= RESET_MID_START;
            pos_reg.slow   <= RESET_SLOW_START;
            mid_phase_reg  <= '0;
            slow_phase_reg <= '0;
            s1_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            pos_reg        <= pos_next;
            mid_phase_reg  <= mid_phase_next;
            slow_phase_reg <= slow_phase_next;
            s1_valid_reg   <= s1_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // payload registers: no reset
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            s1_char_reg   <= s_char_in;
            s1_letter_reg <= in_letter;
            s1_pos_reg    <= cur_pos;
        end
        if (s1_advance) begin
            m_char_reg <= path_char;
        end
    end

    `TRRC_ASSERT_ALWAYS(a_pos_in_range, aclk, aresetn, (pos_reg.fast < 5'(NLET)) && (pos_reg.mid < 5'(NLET)) && (pos_reg.slow < 5'(NLET)), "rotor offset out of range")

    `TRRC_ASSERT_NEXT(a_fast_steps, aclk, aresetn, in_accept && in_letter && !s_new_message, pos_reg.fast == inc26($past(pos_reg.fast)), "fast rotor did not step on a letter")

    `TRRC_ASSERT_NEXT(a_other_holds, aclk, aresetn, in_accept && !in_letter && !s_new_message, $stable(pos_reg) && $stable(mid_phase_reg) && $stable(slow_phase_reg), "non-letter changed rotor state")

    `TRRC_ASSERT_NEXT(a_beat_moves, aclk, aresetn, s1_advance, m_valid_reg, "input stage advanced without filling result stage")

endmodule

// ===== tb/sv/cipher_stream_checker.sv =====
// Stream checker for the three-rotor reflector cipher core: tracks rotor offsets and
// step phases, predicts every output byte and compares it with the result channel.
// Depends on trrc_pkg for register codes, field types and reset values.
`timescale 1ns / 100ps

module cipher_stream_checker
    import trrc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [2:0] cfg_index,
    input  logic [5:0] cfg_wdata,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_char_in,
    input  logic       s_new_message,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [7:0] m_char_out,
    output int         mismatch_count,
    output int         pending_count
);

    localparam int ROTOR_FAST = 0;
    localparam int ROTOR_MID  = 1;
    localparam int ROTOR_SLOW = 2;
    localparam int REFLECTOR  = 3;
    localparam int PHASE_WRAP = 64;

    typedef struct packed {
        logic [7:0] plain;
        logic [7:0] cipher;
    } byte_pair_t;

    letter_t    fwd_map [4][NLET];
    letter_t    inv_map [4][NLET];

    letter_t    fast_start, mid_start, slow_start;
    phase_t     mid_period, slow_period;
    int         fast_pos, mid_pos, slow_pos;
    int         mid_count, slow_count;
    byte_pair_t expected_bytes[$];
    int         errors = 0;

    initial pending_count = 0;

    assign mismatch_count = errors;

    function automatic logic [8*NLET-1:0] wiring_text(input int t);
        case (t)
            ROTOR_FAST: return "VFTYQMDRIOLGHUKZNABWXSJECP";
            ROTOR_MID:  return "XGMPSALUFVKHJZTWRCINOBYDQE";
            ROTOR_SLOW: return "UCLHXATGZRNFOJBIEVSYWPDMKQ";
            default:    return "GKWRVLSHAJUQPDNIMYFTOEBXZC";
        endcase
    endfunction

    initial begin
        logic [8*NLET-1:0] text;
        letter_t v;
        for (int t = 0; t < 4; t++) begin
            text = wiring_text(t);
            for (int k = 0; k < NLET; k++) begin
                v = 5'(text[8*(NLET-1-k) +: 8] - CHAR_A);
                fwd_map[t][k] = v;
                inv_map[t][v] = 5'(k);
            end
        end
    end

    function automatic logic [7:0] encipher(input logic [7:0] c);
        int x;
        if (c < CHAR_A || c > CHAR_Z) return c;
        x = int'(c - CHAR_A);
        x = fwd_map[ROTOR_FAST][(x + NLET - fast_pos) % NLET];
        x = fwd_map[ROTOR_MID][(x + NLET - mid_pos) % NLET];
        x = fwd_map[ROTOR_SLOW][(x + NLET - slow_pos) % NLET];
        // reflect: move half a turn along the reflector table
        x = fwd_map[REFLECTOR][(int'(inv_map[REFLECTOR][x]) + int'(HALF_TURN)) % NLET];
        x = (int'(inv_map[ROTOR_SLOW][x]) + slow_pos) % NLET;
        x = (int'(inv_map[ROTOR_MID][x]) + mid_pos) % NLET;
        x = (int'(inv_map[ROTOR_FAST][x]) + fast_pos) % NLET;
        return CHAR_A + 8'(x);
    endfunction

    task automatic load_start_positions();
        fast_pos   = int'(fast_start) % NLET;
        mid_pos    = int'(mid_start) % NLET;
        slow_pos   = int'(slow_start) % NLET;
        mid_count  = 0;
        slow_count = 0;
    endtask

    // Phases wrap at 64, so a period of zero or one below the phase still fires.
    task automatic advance_rotors();
        fast_pos  = (fast_pos + 1) % NLET;
        mid_count = (mid_count + 1) % PHASE_WRAP;
        if (mid_count == int'(mid_period)) begin
            mid_count = 0;
            mid_pos   = (mid_pos + 1) % NLET;
        end
        slow_count = (slow_count + 1) % PHASE_WRAP;
        if (slow_count == int'(slow_period)) begin
            slow_count = 0;
            slow_pos   = (slow_pos + 1) % NLET;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [7:0] plain,
                                   input logic [7:0] want, input logic [7:0] got);
        errors++;
        $display("[%0t] MISMATCH %s: in %h, expected %h, got %h",
                 $time, what, plain, want, got);
    endtask

    always @(posedge aclk) begin
        byte_pair_t item;
        if (!aresetn) begin
            fast_start  = RESET_FAST_START;
            mid_start   = RESET_MID_START;
            slow_start  = RESET_SLOW_START;
            mid_period  = RESET_MID_PERIOD;
            slow_period = RESET_SLOW_PERIOD;
            load_start_positions();
            expected_bytes.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_reg_t'(cfg_index))
                    REG_FAST_START:  fast_start  = cfg_wdata[4:0];
                    REG_MID_START:   mid_start   = cfg_wdata[4:0];
                    REG_SLOW_START:  slow_start  = cfg_wdata[4:0];
                    REG_MID_PERIOD:  mid_period  = cfg_wdata;
                    REG_SLOW_PERIOD: slow_period = cfg_wdata;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (expected_bytes.size() == 0) begin
                    report_mismatch("char_out beat with nothing outstanding",
                                    8'h00, 8'h00, m_char_out);
                end else begin
                    item = expected_bytes.pop_front();
                    if (m_char_out !== item.cipher)
                        report_mismatch("char_out", item.plain, item.cipher, m_char_out);
                end
            end
            if (s_valid && s_ready) begin
                if (s_new_message) load_start_positions();
                item.plain  = s_char_in;
                item.cipher = encipher(s_char_in);
                if (s_char_in >= CHAR_A && s_char_in <= CHAR_Z) advance_rotors();
                expected_bytes.push_back(item);
            end
        end
        pending_count <= expected_bytes.size();
    end

endmodule

// ===== tb/sv/tb_three_rotor_reflector_cipher_core.sv =====
// Top-level testbench for three_rotor_reflector_cipher_core: drives byte beats and
// register writes with random idling and gives the verdict.
// Depends on trrc_pkg, the core and cipher_stream_checker.
`timescale 1ns / 100ps

module tb_three_rotor_reflector_cipher_core;
    import trrc_pkg::*;

    localparam int         RANDOM_PHASES   = 8;
    localparam int         BEATS_PER_PHASE = 194;
    localparam int         CALM_PHASE      = 3;
    localparam int         IDLE_PERCENT    = 7;
    localparam int         DRAIN_CYCLES    = 4;
    localparam int         WATCHDOG_LIMIT  = 2000;
    localparam logic [2:0] CFG_SPARE_FIRST = 3'd5;
    localparam logic [2:0] CFG_SPARE_LAST  = 3'd7;

    logic       aclk          = 1'b0;
    logic       aresetn       = 1'b0;
    logic       cfg_wr_en     = 1'b0;
    logic [2:0] cfg_index     = '0;
    logic [5:0] cfg_wdata     = '0;
    logic       s_valid       = 1'b0;
    logic       s_ready;
    logic [7:0] s_char_in     = '0;
    logic       s_new_message = 1'b0;
    logic       m_valid;
    logic       m_ready       = 1'b0;
    logic [7:0] m_char_out;
    int         mismatch_count;
    int         pending_count;
    bit         calm          = 1'b0;
    int         quiet_cycles  = 0;

    always #5 aclk = ~aclk;

    three_rotor_reflector_cipher_core i_dut (.*);

    cipher_stream_checker i_checker (.*);

    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else          m_ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("three_rotor_reflector_cipher_core verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_byte(input logic [7:0] c, input logic reload);
        while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_char_in     <= c;
        s_new_message <= reload;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Drop valid, let every expected beat come back, then cover the pipeline depth.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_count != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_cfg(input logic [2:0] idx, input logic [5:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
    endtask

    task automatic program_rotors(input logic [5:0] fast, input logic [5:0] mid,
                                  input logic [5:0] slow, input logic [5:0] mid_per,
                                  input logic [5:0] slow_per);
        wait_drained();
        write_cfg(REG_FAST_START, fast);
        write_cfg(REG_MID_START, mid);
        write_cfg(REG_SLOW_START, slow);
        write_cfg(REG_MID_PERIOD, mid_per);
        write_cfg(REG_SLOW_PERIOD, slow_per);
        // unmapped indexes must leave every register alone
        if ($urandom_range(1) == 1)
            write_cfg(3'($urandom_range(CFG_SPARE_LAST, CFG_SPARE_FIRST)),
                      6'($urandom_range(63)));
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [7:0] pick_byte();
        int roll;
        roll = $urandom_range(99);
        if (roll < 82) return 8'($urandom_range(int'(CHAR_Z), int'(CHAR_A)));
        if (roll < 86) return (roll % 2 == 0) ? CHAR_A - 8'd1 : CHAR_Z + 8'd1;
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [5:0] pick_start();
        case ($urandom_range(4))
            0:       return 6'd0;
            1:       return 6'd25;
            2:       return 6'($urandom_range(31, 26));
            default: return 6'($urandom_range(63));
        endcase
    endfunction

    function automatic logic [5:0] pick_period();
        case ($urandom_range(6))
            0:       return 6'd0;
            1:       return 6'd1;
            2:       return 6'd63;
            3:       return 6'($urandom_range(63));
            default: return 6'($urandom_range(12, 2));
        endcase
    endfunction

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: letter bounds, neighbors of the letter range, byte extremes, a lowercase byte and reloads
        send_byte(CHAR_A, 1'b0);
        send_byte(CHAR_Z, 1'b0);
        send_byte(CHAR_A - 8'd1, 1'b0);
        send_byte(CHAR_Z + 8'd1, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h51, 1'b1);
        send_byte(8'h20, 1'b1);
        send_byte(8'h51, 1'b0);

        // start positions past 25 wrap on reload; step every letter and every 63rd
        program_rotors(6'd31, 6'd26, 6'd0, 6'd1, 6'd63);
        for (int i = 0; i < 5; i++) send_byte(CHAR_A + 8'(i), i == 0);

        // shrink periods under the running phases without a reload; zero period
        program_rotors(6'd63, 6'd32, 6'd7, 6'd0, 6'd2);
        for (int i = 0; i < 5; i++) send_byte(CHAR_Z - 8'(i), 1'b0);

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0:       program_rotors(6'd0, 6'd0, 6'd0, 6'd0, 6'd2);
                1:       program_rotors(6'd25, 6'd25, 6'd25, 6'd1, 6'd63);
                2:       program_rotors(6'd31, 6'd30, 6'd26, 6'd63, 6'd0);
                default: program_rotors(pick_start(), pick_start(), pick_start(),
                                        pick_period(), pick_period());
            endcase
            calm = (ph == CALM_PHASE);
            for (int n = 0; n < BEATS_PER_PHASE; n++) begin
                if (n == 0)
                    send_byte(pick_byte(), (ph == 0) ? 1'b0 : 1'($urandom_range(1)));
                else
                    send_byte(pick_byte(), $urandom_range(99) < 2);
            end
        end
        calm = 1'b0;

        wait_drained();
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("three_rotor_reflector_cipher_core verification clean");
        end else begin
            $display("three_rotor_reflector_cipher_core verification failed");
        end
        $finish;
    end

endmodule
